[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk while rst_n is high.
`define HPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that an antecedent implies a consequent in the following cycle.
`define HPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hpt_pkg.sv]
// Package with the constants, types and helpers of the point transform.
package hpt_pkg;

    localparam int COORD_W    = 32;
    localparam int ACC_W      = 64;
    localparam int LOW_W      = 16;
    localparam int QUO_W      = 32;
    localparam int DIV_STEPS  = 32;
    localparam int NUM_LANES  = 3;
    localparam int NUM_COLS   = 4;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int ZERO_THRESHOLD = 1;

    // Threshold on |w| in the Q.30 accumulator scale.
    localparam logic [ACC_W-1:0] W_LIMIT = ACC_W'(ZERO_THRESHOLD) << 14;

    localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] mtx_t;

    // Register 7 on the left, register 0 on the right.
    localparam mtx_t MTX_RESET = {
        64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0001_0000_0000};

    // One coordinate on its way through the divider.
    typedef struct packed {
        logic [ACC_W-1:0]   rem;
        logic [LOW_W-1:0]   low;
        logic [QUO_W-1:0]   quo;
        logic               neg;
        logic               pre_ovf;
        logic [COORD_W-1:0] flat;
        logic               flat_ovf;
    } lane_t;

    typedef lane_t [NUM_LANES-1:0] lanes_t;

    // Coefficient m[row][col] from the register file.
    function automatic logic signed [COORD_W-1:0] coef(mtx_t m, int row, int col);
        logic [CFG_DATA_W-1:0] r;
        r = m[3'(row * 2 + (col >> 1))];
        return ((col & 1) != 0) ? r[63:32] : r[31:0];
    endfunction

endpackage

[hw/rtl/hpt_if.sv]
// Valid/ready channel interfaces for input points and transformed results.
interface hpt_in_if;
    import hpt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    modport source (output valid, in_x, in_y, in_z, input ready);
    modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface hpt_out_if;
    import hpt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      divided;
    logic                      overflow;
    modport source (output valid, out_x, out_y, out_z, divided, overflow, input ready);
    modport sink (input valid, out_x, out_y, out_z, divided, overflow, output ready);
endinterface

[hw/rtl/homogeneous_point_transform_top.sv]
// Top level of the 4x4 homogeneous point transform with perspective divide.
//
// Usage: points (in_x, in_y, in_z, signed Q16.16) arrive on the in_ch
// valid/ready channel; each yields exactly one result on out_ch with the
// transformed, saturated coordinates, a divided flag and an overflow flag.
// The matrix lives in eight 64-bit registers written through cfg_we,
// cfg_index and cfg_data; indexes beyond the eighth register are ignored.
// Write the matrix only while no item is in flight.
// Pipeline: from acceptance to a valid result, an item passes five stages of
// multiply, accumulate and divider setup, 32 stages of the one-bit-per-stage
// quotient pipeline, and the output register.
// Throughput: one item per cycle while the output is not stalled, set by the
// fully pipelined multipliers and divider steps.
// Reset: clears all valid bits and loads the default matrix registers.
// Stall: while out_ch.ready is low and a result waits, the whole pipeline
// holds and in_ch.ready is low; no item is lost or repeated.
`include "assert_macros.svh"

module homogeneous_point_transform_top
    import hpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    hpt_in_if.sink                in_ch,
    hpt_out_if.source             out_ch
);

    mtx_t mtx_reg;
    logic en;
    logic out_valid_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic out_div_reg, out_ovf_reg;

    logic   [DIV_STEPS:0]            vld;
    logic   [DIV_STEPS:0][ACC_W-1:0] nd;
    logic   [DIV_STEPS:0]            dv;
    lanes_t [DIV_STEPS:0]            lanes;

    logic [NUM_LANES-1:0][COORD_W-1:0] res;
    logic [NUM_LANES-1:0]              res_ovf;

    // The pipeline advances unless a result waits at a stalled output.
    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // Matrix register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mtx_reg <= MTX_RESET;
        else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS))
            mtx_reg[cfg_index[2:0]] <= cfg_data;
    end

    hpt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_valid(in_ch.valid),
        .in_x    (in_ch.in_x),
        .in_y    (in_ch.in_y),
        .in_z    (in_ch.in_z),
        .mtx     (mtx_reg),
        .valid   (vld[0]),
        .nd      (nd[0]),
        .divided (dv[0]),
        .lanes   (lanes[0])
    );

    // Quotient pipeline: one bit of each quotient per stage.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        hpt_div_step u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .valid_in   (vld[k]),
            .nd_in      (nd[k]),
            .divided_in (dv[k]),
            .lanes_in   (lanes[k]),
            .valid_out  (vld[k+1]),
            .nd_out     (nd[k+1]),
            .divided_out(dv[k+1]),
            .lanes_out  (lanes[k+1])
        );
    end

    // Sign, saturation and choice between divided and undivided results.
    always_comb
    begin
        lane_t ln;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            ln = lanes[DIV_STEPS][l];
            if (!dv[DIV_STEPS])
            begin
                res[l]     = ln.flat;
                res_ovf[l] = ln.flat_ovf;
            end
            else if (ln.neg)
            begin
                res_ovf[l] = ln.pre_ovf || (ln.quo > SAT_NEG);
                res[l]     = res_ovf[l] ? SAT_NEG : -ln.quo;
            end
            else
            begin
                res_ovf[l] = ln.pre_ovf || ln.quo[QUO_W-1];
                res[l]     = res_ovf[l] ? SAT_POS : ln.quo;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg   <= res[0];
            out_y_reg   <= res[1];
            out_z_reg   <= res[2];
            out_div_reg <= dv[DIV_STEPS];
            out_ovf_reg <= |res_ovf;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_x    = out_x_reg;
    assign out_ch.out_y    = out_y_reg;
    assign out_ch.out_z    = out_z_reg;
    assign out_ch.divided  = out_div_reg;
    assign out_ch.overflow = out_ovf_reg;

    // Input is refused only while a finished result is held.
    `HPT_ASSERT(a_ready_only_stalled, (!in_ch.ready |-> out_ch.valid), "ready low without held result")
    // An item in the divider moves on when the pipeline advances.
    `HPT_ASSERT_NEXT(a_div_advance, en && vld[0], vld[1], "item lost in divider")
    // A stall freezes every valid bit in the divider.
    `HPT_ASSERT_NEXT(a_stall_holds, !en, $stable(vld), "divider changed during stall")

endmodule

[hw/rtl/hpt_front.sv]
// Matrix multiply, accumulation and divider setup: five register stages.
module hpt_front
    import hpt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic signed [COORD_W-1:0] in_z,
    input  mtx_t                      mtx,
    output logic                      valid,
    output logic [ACC_W-1:0]          nd,
    output logic                      divided,
    output lanes_t                    lanes
);

    logic [4:0] v_reg;
    logic signed [ACC_W-1:0]   prod_reg [NUM_COLS][NUM_LANES];
    logic signed [COORD_W-1:0] tr_reg [NUM_COLS];
    logic signed [ACC_W-1:0]   s01_reg [NUM_COLS];
    logic signed [ACC_W-1:0]   s2t_reg [NUM_COLS];
    logic signed [ACC_W-1:0]   acc_reg [NUM_COLS];
    logic [ACC_W-1:0]          nd4_reg;
    logic [ACC_W-1:0]          na_reg [NUM_LANES];
    logic [NUM_LANES-1:0]      neg_reg;
    logic [COORD_W-1:0]        flat_reg [NUM_LANES];
    logic [NUM_LANES-1:0]      fovf_reg;
    logic [ACC_W-1:0]          nd_reg;
    logic                      div_reg;
    lanes_t                    lanes_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    // Stage 1: twelve products and the translation terms.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                prod_reg[c][0] <= coef(mtx, 0, c) * in_x;
                prod_reg[c][1] <= coef(mtx, 1, c) * in_y;
                prod_reg[c][2] <= coef(mtx, 2, c) * in_z;
                tr_reg[c]      <= coef(mtx, 3, c);
            end
        end
    end

    // Stages 2 and 3: floor to Q.30 and add the four terms in two levels.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                s01_reg[c] <= (prod_reg[c][0] >>> 2) + (prod_reg[c][1] >>> 2);
                s2t_reg[c] <= (prod_reg[c][2] >>> 2) + (ACC_W'(tr_reg[c]) <<< 14);
                acc_reg[c] <= s01_reg[c] + s2t_reg[c];
            end
        end
    end

    // Stage 4: magnitudes, signs and the saturated undivided result.
    always_ff @(posedge clk)
    begin
        logic signed [ACC_W-1:0] sh;
        if (en)
        begin
            nd4_reg <= acc_reg[3][ACC_W-1] ? -acc_reg[3] : acc_reg[3];
            for (int l = 0; l < NUM_LANES; l++)
            begin
                sh = acc_reg[l] >>> 14;
                na_reg[l]  <= acc_reg[l][ACC_W-1] ? -acc_reg[l] : acc_reg[l];
                neg_reg[l] <= acc_reg[l][ACC_W-1] ^ acc_reg[3][ACC_W-1];
                if (sh[ACC_W-1:COORD_W-1] != '0 && sh[ACC_W-1:COORD_W-1] != '1)
                begin
                    fovf_reg[l] <= 1'b1;
                    flat_reg[l] <= sh[ACC_W-1] ? SAT_NEG : SAT_POS;
                end
                else
                begin
                    fovf_reg[l] <= 1'b0;
                    flat_reg[l] <= sh[COORD_W-1:0];
                end
            end
        end
    end

    // Stage 5: divide decision and the integer part check of each quotient.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_reg  <= nd4_reg;
            div_reg <= nd4_reg > W_LIMIT;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                lanes_reg[l].rem      <= na_reg[l] >> LOW_W;
                lanes_reg[l].low      <= na_reg[l][LOW_W-1:0];
                lanes_reg[l].quo      <= '0;
                lanes_reg[l].neg      <= neg_reg[l];
                lanes_reg[l].pre_ovf  <= (na_reg[l] >> LOW_W) >= nd4_reg;
                lanes_reg[l].flat     <= flat_reg[l];
                lanes_reg[l].flat_ovf <= fovf_reg[l];
            end
        end
    end

    assign valid   = v_reg[4];
    assign nd      = nd_reg;
    assign divided = div_reg;
    assign lanes   = lanes_reg;

endmodule

[hw/rtl/hpt_div_step.sv]
// One restoring division step for all three coordinates, registered.
module hpt_div_step
    import hpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  logic [ACC_W-1:0] nd_in,
    input  logic             divided_in,
    input  lanes_t           lanes_in,
    output logic             valid_out,
    output logic [ACC_W-1:0] nd_out,
    output logic             divided_out,
    output lanes_t           lanes_out
);

    logic             valid_reg;
    logic [ACC_W-1:0] nd_reg;
    logic             div_reg;
    lanes_t           lanes_reg;
    lanes_t           lanes_next;

    // Bring down the next dividend bit and subtract the divisor if it fits.
    always_comb
    begin
        logic [ACC_W-1:0] r2;
        logic             ge;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            r2 = {lanes_in[l].rem[ACC_W-2:0], lanes_in[l].low[LOW_W-1]};
            ge = r2 >= nd_in;
            lanes_next[l]     = lanes_in[l];
            lanes_next[l].rem = ge ? r2 - nd_in : r2;
            lanes_next[l].low = {lanes_in[l].low[LOW_W-2:0], 1'b0};
            lanes_next[l].quo = {lanes_in[l].quo[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_reg    <= nd_in;
            div_reg   <= divided_in;
            lanes_reg <= lanes_next;
        end
    end

    assign valid_out   = valid_reg;
    assign nd_out      = nd_reg;
    assign divided_out = div_reg;
    assign lanes_out   = lanes_reg;

endmodule
